[hw/rtl/bsrf_pkg.sv]
// ----------------------------------------------------------------------------
// bsrf_pkg
// Shared constants and codes of the bam stream record framer.
// ----------------------------------------------------------------------------
package bsrf_pkg;

    localparam int OFFSET_BITS = 48;
    localparam int OUT_OFFSET_BITS = 48;
    localparam int LEN_BITS = 32;

    localparam int TDATA_IN_BITS = 8;
    localparam int TDATA_OUT_BITS = 8 + 3 * LEN_BITS + OUT_OFFSET_BITS;
    localparam int TUSER_OUT_BITS = 7;

    typedef logic [OFFSET_BITS-1:0] t_offset;
    typedef logic [LEN_BITS-1:0] t_len;

    typedef enum logic [3:0] {
        SEC_MAGIC  = 4'd0,
        SEC_L_TEXT = 4'd1,
        SEC_TEXT   = 4'd2,
        SEC_N_REF  = 4'd3,
        SEC_L_NAME = 4'd4,
        SEC_NAME   = 4'd5,
        SEC_L_REF  = 4'd6,
        SEC_BLOCK  = 4'd7,
        SEC_BODY   = 4'd8
    } t_section;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_HEADER = 3'd1,
        EV_N_REF  = 3'd2,
        EV_REF    = 3'd3,
        EV_ALIGN  = 3'd4
    } t_event;

endpackage

[hw/rtl/bam_stream_record_framer.sv]
// ----------------------------------------------------------------------------
// bam_stream_record_framer
// Byte-serial framer that tags each decompressed bam byte with its role and
// reports the completion of header, n_ref, reference and alignment units.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one stream byte per item in tdata[7:0].
//   m_axis returns one item per input byte: tdata holds the byte, the unit
//   lengths, the reference index and the unit start offset; tuser holds the
//   byte role and the event kind.
//   an accepted byte waits in the input register, which feeds one pass of
//   section logic that loads the output register.
//   throughput is one byte per cycle while m_axis_tready is high, set by the
//   section update; a new byte is taken while a finished item waits on m_axis.
//   when the receiver stalls, the output register holds its item and the
//   input register fills, then s_axis_tready drops until m_axis_tready rises.
//   reset empties both registers and returns the framer to the magic section
//   at stream offset zero.
// ----------------------------------------------------------------------------
module bam_stream_record_framer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // stream_byte
    input  logic [bsrf_pkg::TDATA_IN_BITS-1:0]  s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // data_byte, event_length, event_ref_length, event_index, event_offset
    output logic [bsrf_pkg::TDATA_OUT_BITS-1:0] m_axis_tdata,
    // role, event_kind
    output logic [bsrf_pkg::TUSER_OUT_BITS-1:0] m_axis_tuser
);
    import bsrf_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       w_advance;

    t_section r_section, n_section;
    t_len     r_bytes, n_bytes;
    t_len     r_primary, n_primary;
    t_len     r_secondary, n_secondary;
    t_len     r_ref_total, n_ref_total;
    t_len     r_ref_num, n_ref_num;
    t_offset  r_position;
    t_offset  r_unit_start, n_unit_start;

    logic                       r_out_valid;
    logic [7:0]                 r_out_byte;
    t_section                   r_out_role;
    t_event                     r_out_event;
    t_len                       r_out_len;
    t_len                       r_out_rlen;
    t_len                       r_out_idx;
    logic [OUT_OFFSET_BITS-1:0] r_out_off;

    t_section                   n_role;
    t_event                     n_event;
    t_len                       n_len;
    t_len                       n_rlen;
    t_len                       n_idx;
    logic [OUT_OFFSET_BITS-1:0] n_off;

    logic [1:0] w_lane;
    t_len       w_byte_wide;
    t_len       w_gather_p;
    t_len       w_gather_s;
    logic       w_word_done;
    t_len       w_bytes_inc;
    t_len       w_ref_inc;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    // little-endian word gathering
    assign w_lane      = r_bytes[1:0];
    assign w_byte_wide = LEN_BITS'(r_in_byte) << {w_lane, 3'b000};
    assign w_gather_p  = ((w_lane == 2'd0) ? '0 : r_primary) | w_byte_wide;
    assign w_gather_s  = ((w_lane == 2'd0) ? '0 : r_secondary) | w_byte_wide;
    assign w_word_done = (w_lane == 2'd3);
    assign w_bytes_inc = r_bytes + 1'b1;
    assign w_ref_inc   = r_ref_num + 1'b1;

    always_comb begin
        n_section    = r_section;
        n_bytes      = r_bytes;
        n_primary    = r_primary;
        n_secondary  = r_secondary;
        n_ref_total  = r_ref_total;
        n_ref_num    = r_ref_num;
        n_unit_start = r_unit_start;
        n_role       = r_section;
        n_event      = EV_NONE;
        n_len        = '0;
        n_rlen       = '0;
        n_idx        = '0;
        n_off        = '0;
        unique case (r_section)
            SEC_MAGIC: begin
                if (r_bytes == '0) begin
                    n_unit_start = r_position;
                end
                if (w_bytes_inc >= LEN_BITS'(4)) begin
                    n_bytes   = '0;
                    n_section = SEC_L_TEXT;
                end else begin
                    n_bytes = w_bytes_inc;
                end
            end
            SEC_L_TEXT: begin
                n_primary = w_gather_p;
                n_bytes   = w_word_done ? '0 : w_bytes_inc;
                if (w_word_done) begin
                    if (w_gather_p == '0) begin
                        n_event   = EV_HEADER;
                        n_off     = OUT_OFFSET_BITS'(r_unit_start);
                        n_section = SEC_N_REF;
                    end else begin
                        n_section = SEC_TEXT;
                    end
                end
            end
            SEC_TEXT: begin
                n_bytes = w_bytes_inc;
                if (w_bytes_inc == r_primary) begin
                    n_event   = EV_HEADER;
                    n_len     = r_primary;
                    n_off     = OUT_OFFSET_BITS'(r_unit_start);
                    n_bytes   = '0;
                    n_section = SEC_N_REF;
                end
            end
            SEC_N_REF: begin
                if (r_bytes == '0) begin
                    n_unit_start = r_position;
                end
                n_primary = w_gather_p;
                n_bytes   = w_word_done ? '0 : w_bytes_inc;
                if (w_word_done) begin
                    n_ref_total = w_gather_p;
                    n_ref_num   = '0;
                    n_event     = EV_N_REF;
                    n_len       = w_gather_p;
                    n_off       = OUT_OFFSET_BITS'(n_unit_start);
                    n_section   = (w_gather_p == '0) ? SEC_BLOCK : SEC_L_NAME;
                end
            end
            SEC_L_NAME: begin
                if (r_bytes == '0) begin
                    n_unit_start = r_position;
                end
                n_primary = w_gather_p;
                n_bytes   = w_word_done ? '0 : w_bytes_inc;
                if (w_word_done) begin
                    n_section = (w_gather_p == '0) ? SEC_L_REF : SEC_NAME;
                end
            end
            SEC_NAME: begin
                n_bytes = w_bytes_inc;
                if (w_bytes_inc == r_primary) begin
                    n_bytes   = '0;
                    n_section = SEC_L_REF;
                end
            end
            SEC_L_REF: begin
                n_secondary = w_gather_s;
                n_bytes     = w_word_done ? '0 : w_bytes_inc;
                if (w_word_done) begin
                    n_event   = EV_REF;
                    n_len     = r_primary;
                    n_rlen    = w_gather_s;
                    n_idx     = r_ref_num;
                    n_off     = OUT_OFFSET_BITS'(r_unit_start);
                    n_ref_num = w_ref_inc;
                    n_section = (w_ref_inc == r_ref_total) ? SEC_BLOCK : SEC_L_NAME;
                end
            end
            SEC_BODY: begin
                n_bytes = w_bytes_inc;
                if (w_bytes_inc == r_primary) begin
                    n_event   = EV_ALIGN;
                    n_len     = r_primary;
                    n_off     = OUT_OFFSET_BITS'(r_unit_start);
                    n_bytes   = '0;
                    n_section = SEC_BLOCK;
                end
            end
            default: begin
                // record length word, also recovery from unused codes
                n_section = SEC_BLOCK;
                n_role    = SEC_BLOCK;
                if (r_bytes == '0) begin
                    n_unit_start = r_position;
                end
                n_primary = w_gather_p;
                n_bytes   = w_word_done ? '0 : w_bytes_inc;
                if (w_word_done) begin
                    if (w_gather_p == '0) begin
                        n_event = EV_ALIGN;
                        n_off   = OUT_OFFSET_BITS'(n_unit_start);
                    end else begin
                        n_section = SEC_BODY;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_section    <= SEC_MAGIC;
            r_bytes      <= '0;
            r_primary    <= '0;
            r_secondary  <= '0;
            r_ref_total  <= '0;
            r_ref_num    <= '0;
            r_position   <= '0;
            r_unit_start <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid  <= 1'b1;
                r_section    <= n_section;
                r_bytes      <= n_bytes;
                r_primary    <= n_primary;
                r_secondary  <= n_secondary;
                r_ref_total  <= n_ref_total;
                r_ref_num    <= n_ref_num;
                r_position   <= r_position + 1'b1;
                r_unit_start <= n_unit_start;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
        if (w_advance) begin
            r_out_byte  <= r_in_byte;
            r_out_role  <= n_role;
            r_out_event <= n_event;
            r_out_len   <= n_len;
            r_out_rlen  <= n_rlen;
            r_out_idx   <= n_idx;
            r_out_off   <= n_off;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_off, r_out_idx, r_out_rlen, r_out_len, r_out_byte};
    assign m_axis_tuser  = {r_out_event, r_out_role};

    a_no_event_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_event == EV_NONE) |->
        (r_out_len == '0 && r_out_rlen == '0 && r_out_idx == '0 && r_out_off == '0))
        else $error("event fields set without an event");

    a_ref_event_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_event == EV_REF) |-> (r_out_role == SEC_L_REF))
        else $error("reference event on a byte that is not l_ref");

    a_header_event_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_event == EV_HEADER) |->
        (r_out_role == SEC_L_TEXT || r_out_role == SEC_TEXT))
        else $error("header event on a byte outside the header");

    a_magic_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_role == SEC_MAGIC) |-> (r_out_event == EV_NONE))
        else $error("event on a magic byte");

    a_gather_lane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_section == SEC_L_TEXT || r_section == SEC_N_REF || r_section == SEC_L_NAME ||
         r_section == SEC_L_REF || r_section == SEC_BLOCK || r_section == SEC_MAGIC) |->
        (r_bytes < LEN_BITS'(4)))
        else $error("byte count beyond a length word");

    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> ($stable(r_section) && $stable(r_position)))
        else $error("framer state moved without an item");

endmodule
